FILE: rtl/triangle_unit_normal_defines.svh
// assertion macros used by the port checks of the triangle unit normal block
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TUN_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tun check failed");

// consequent must hold in the cycle after the antecedent
`define TUN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tun check failed");

`endif

FILE: rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// types and fixed widths of the triangle unit normal block
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int HALF_W     = EDGE_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } tun_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] norm_x;
        logic signed [OUT_BITS-1:0] norm_y;
        logic signed [OUT_BITS-1:0] norm_z;
        logic                       degenerate;
    } tun_out_t;

    // per-request control that travels beside the data
    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } tun_ctrl_t;

endpackage

FILE: rtl/tun_cross.sv
// ----------------------------------------------------------------------------
// tun_cross
// edge vectors, exact cross product, component magnitudes and signs
// ----------------------------------------------------------------------------
module tun_cross (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  tun_pkg::tun_in_t              in_data,
    output tun_pkg::tun_ctrl_t            ctrl_out,
    output logic [tun_pkg::MAG_W-1:0]     mag_out [3]
);
    import tun_pkg::*;

    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic                      vb_reg;
    logic signed [PROD_W-1:0]  pa_reg [3];
    logic signed [PROD_W-1:0]  pb_reg [3];
    logic                      vc_reg;
    logic signed [CROSS_W-1:0] n_next [3];
    logic [MAG_W-1:0]          mag_next [3];
    logic [2:0]                neg_next;
    logic [MAG_W-1:0]          mag_reg [3];
    tun_ctrl_t                 ctrl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            vb_reg         <= in_valid;
            vc_reg         <= vb_reg;
            ctrl_reg.valid <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg[0] <= EDGE_W'(in_data.a_x) - EDGE_W'(in_data.b_x);
            e1_reg[1] <= EDGE_W'(in_data.a_y) - EDGE_W'(in_data.b_y);
            e1_reg[2] <= EDGE_W'(in_data.a_z) - EDGE_W'(in_data.b_z);
            e2_reg[0] <= EDGE_W'(in_data.c_x) - EDGE_W'(in_data.b_x);
            e2_reg[1] <= EDGE_W'(in_data.c_y) - EDGE_W'(in_data.b_y);
            e2_reg[2] <= EDGE_W'(in_data.c_z) - EDGE_W'(in_data.b_z);
            pa_reg[0] <= e1_reg[1] * e2_reg[2];
            pb_reg[0] <= e2_reg[1] * e1_reg[2];
            pa_reg[1] <= e2_reg[0] * e1_reg[2];
            pb_reg[1] <= e1_reg[0] * e2_reg[2];
            pa_reg[2] <= e1_reg[0] * e2_reg[1];
            pb_reg[2] <= e2_reg[0] * e1_reg[1];
            mag_reg        <= mag_next;
            ctrl_reg.neg   <= neg_next;
            ctrl_reg.degen <= 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_next[i]   = CROSS_W'(pa_reg[i]) - CROSS_W'(pb_reg[i]);
            neg_next[i] = !n_next[i][CROSS_W-1] && (n_next[i] != '0);
            mag_next[i] = n_next[i][CROSS_W-1] ? MAG_W'(-n_next[i]) : MAG_W'(n_next[i]);
        end
    end

    assign ctrl_out = ctrl_reg;
    assign mag_out  = mag_reg;

endmodule

FILE: rtl/tun_prep.sv
// ----------------------------------------------------------------------------
// tun_prep
// squares of the components, squared length and start values of the cells
// ----------------------------------------------------------------------------
module tun_prep #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  tun_pkg::tun_ctrl_t                            ctrl_in,
    input  logic [tun_pkg::MAG_W-1:0]                     mag_in [3],
    output tun_pkg::tun_ctrl_t                            ctrl_out,
    output logic [tun_pkg::SUM_W-1:0]                     s_out,
    output logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   r_out [3],
    output logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   p_out [3],
    output logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   y_out [3],
    output logic [FRAC_BITS:0]                            q_out [3]
);
    import tun_pkg::*;

    localparam int PW = SQ_W + 2 * FRAC_BITS + 8;

    logic [PROD_W-1:0]        hh_reg [3];
    logic [PROD_W-1:0]        hl_reg [3];
    logic [PROD_W-1:0]        ll_reg [3];
    logic [SQ_W-1:0]          c2_reg [3];
    logic [SUM_W-1:0]         s_next;
    logic [SUM_W-1:0]         s_reg;
    logic signed [PW-1:0]     r_reg [3];
    logic signed [PW-1:0]     p_reg [3];
    logic signed [PW-1:0]     y_reg [3];
    logic [FRAC_BITS:0]       q_reg [3];
    tun_ctrl_t                ce_reg;
    tun_ctrl_t                cf_reg;
    tun_ctrl_t                cg_reg;

    assign s_next = SUM_W'(c2_reg[0]) + SUM_W'(c2_reg[1]) + SUM_W'(c2_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ce_reg.valid <= 1'b0;
            cf_reg.valid <= 1'b0;
            cg_reg.valid <= 1'b0;
        end else if (en) begin
            ce_reg.valid <= ctrl_in.valid;
            cf_reg.valid <= ce_reg.valid;
            cg_reg.valid <= cf_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ce_reg.neg   <= ctrl_in.neg;
            ce_reg.degen <= ctrl_in.degen;
            cf_reg.neg   <= ce_reg.neg;
            cf_reg.degen <= ce_reg.degen;
            cg_reg.neg   <= cf_reg.neg;
            cg_reg.degen <= (s_next == '0);
            s_reg        <= s_next;
            for (int i = 0; i < 3; i++) begin
                // square split in halves to keep the multipliers narrow
                hh_reg[i] <= mag_in[i][MAG_W-1:HALF_W] * mag_in[i][MAG_W-1:HALF_W];
                hl_reg[i] <= mag_in[i][MAG_W-1:HALF_W] * mag_in[i][HALF_W-1:0];
                ll_reg[i] <= mag_in[i][HALF_W-1:0] * mag_in[i][HALF_W-1:0];
                c2_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * HALF_W))
                           + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                           + SQ_W'(ll_reg[i]);
                r_reg[i]  <= $signed(PW'(c2_reg[i])) <<< (2 * FRAC_BITS + 2);
                p_reg[i]  <= $signed(PW'(s_next));
                y_reg[i]  <= -$signed(PW'(s_next));
                q_reg[i]  <= '0;
            end
        end
    end

    assign ctrl_out = cg_reg;
    assign s_out    = s_reg;
    assign r_out    = r_reg;
    assign p_out    = p_reg;
    assign y_out    = y_reg;
    assign q_out    = q_reg;

endmodule

FILE: rtl/tun_cell.sv
// ----------------------------------------------------------------------------
// tun_cell
// one quotient bit of all three components by exact compare
// ----------------------------------------------------------------------------
module tun_cell #(
    parameter int FRAC_BITS = 14,
    parameter int BIT       = 14
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  tun_pkg::tun_ctrl_t                            ctrl_in,
    input  logic [tun_pkg::SUM_W-1:0]                     s_in,
    input  logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   r_in [3],
    input  logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   p_in [3],
    input  logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   y_in [3],
    input  logic [FRAC_BITS:0]                            q_in [3],
    output tun_pkg::tun_ctrl_t                            ctrl_out,
    output logic [tun_pkg::SUM_W-1:0]                     s_out,
    output logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   r_out [3],
    output logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   p_out [3],
    output logic signed [tun_pkg::SQ_W+2*FRAC_BITS+7:0]   y_out [3],
    output logic [FRAC_BITS:0]                            q_out [3]
);
    import tun_pkg::*;

    localparam int PW = SQ_W + 2 * FRAC_BITS + 8;
    localparam int QW = FRAC_BITS + 1;

    // p holds k*k*s and y holds k*s for k = 2q - 1
    logic signed [PW-1:0] sw;
    logic signed [PW-1:0] cand [3];
    logic                 take [3];
    logic signed [PW-1:0] p_next [3];
    logic signed [PW-1:0] y_next [3];
    logic [QW-1:0]        q_next [3];
    logic signed [PW-1:0] r_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [PW-1:0] y_reg [3];
    logic [QW-1:0]        q_reg [3];
    logic [SUM_W-1:0]     s_reg;
    tun_ctrl_t            ctrl_reg;

    assign sw = $signed(PW'(s_in));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cand[i]   = p_in[i] + (y_in[i] <<< (BIT + 2)) + (sw <<< (2 * BIT + 2));
            // a full unit quotient takes no further bits
            take[i]   = !q_in[i][FRAC_BITS] && (cand[i] <= r_in[i]);
            p_next[i] = take[i] ? cand[i] : p_in[i];
            y_next[i] = take[i] ? y_in[i] + (sw <<< (BIT + 1)) : y_in[i];
            q_next[i] = take[i] ? (q_in[i] | (QW'(1) << BIT)) : q_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg.valid <= ctrl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg.degen <= ctrl_in.degen;
            ctrl_reg.neg   <= ctrl_in.neg;
            s_reg          <= s_in;
            r_reg          <= r_in;
            p_reg          <= p_next;
            y_reg          <= y_next;
            q_reg          <= q_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign s_out    = s_reg;
    assign r_out    = r_reg;
    assign p_out    = p_reg;
    assign y_out    = y_reg;
    assign q_out    = q_reg;

endmodule

FILE: rtl/triangle_unit_normal.sv
// throughput: one triangle per cycle; the pipeline moves whenever the result
// register is empty or being taken
// quotient bits come from a row of FRAC_BITS + 1 cells, one bit per cell
// reset (aresetn low, synchronous) clears the valid bits of every stage
// ----------------------------------------------------------------------------
// triangle_unit_normal
// negated unit face normal of a triangle in signed fixed point
// ----------------------------------------------------------------------------
module triangle_unit_normal #(
    parameter int FRAC_BITS = 14
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tun_pkg::tun_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tun_pkg::tun_out_t m_data
);
    import tun_pkg::*;

    localparam int PW    = SQ_W + 2 * FRAC_BITS + 8;
    localparam int QW    = FRAC_BITS + 1;
    localparam int EXT_W = (QW > OUT_BITS) ? QW : OUT_BITS;
    localparam int NC    = FRAC_BITS + 1;

    logic                 en;
    tun_ctrl_t            cross_ctrl;
    logic [MAG_W-1:0]     mag [3];
    tun_ctrl_t            ctrl_ch [NC+1];
    logic [SUM_W-1:0]     s_ch [NC+1];
    logic signed [PW-1:0] r_ch [NC+1][3];
    logic signed [PW-1:0] p_ch [NC+1][3];
    logic signed [PW-1:0] y_ch [NC+1][3];
    logic [QW-1:0]        q_ch [NC+1][3];
    logic [EXT_W-1:0]     q_ext [3];
    logic [EXT_W-1:0]     v_ext [3];
    logic [OUT_BITS-1:0]  norm [3];
    logic                 m_valid_reg;
    tun_out_t             m_data_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    tun_cross u_cross (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .ctrl_out (cross_ctrl),
        .mag_out  (mag)
    );

    tun_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_in  (cross_ctrl),
        .mag_in   (mag),
        .ctrl_out (ctrl_ch[0]),
        .s_out    (s_ch[0]),
        .r_out    (r_ch[0]),
        .p_out    (p_ch[0]),
        .y_out    (y_ch[0]),
        .q_out    (q_ch[0])
    );

    for (genvar j = 0; j < NC; j++) begin : g_cell
        tun_cell #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - j)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_in  (ctrl_ch[j]),
            .s_in     (s_ch[j]),
            .r_in     (r_ch[j]),
            .p_in     (p_ch[j]),
            .y_in     (y_ch[j]),
            .q_in     (q_ch[j]),
            .ctrl_out (ctrl_ch[j+1]),
            .s_out    (s_ch[j+1]),
            .r_out    (r_ch[j+1]),
            .p_out    (p_ch[j+1]),
            .y_out    (y_ch[j+1]),
            .q_out    (q_ch[j+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q_ext[i] = EXT_W'(q_ch[NC][i]);
            // a positive cross component gives a negative normal component
            v_ext[i] = ctrl_ch[NC].neg[i] ? -q_ext[i] : q_ext[i];
            norm[i]  = ctrl_ch[NC].degen ? '0 : v_ext[i][OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctrl_ch[NC].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.norm_x     <= norm[0];
            m_data_reg.norm_y     <= norm[1];
            m_data_reg.norm_z     <= norm[2];
            m_data_reg.degenerate <= ctrl_ch[NC].degen;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/tun_checker.sv
// ----------------------------------------------------------------------------
// tun_port_checks
// port-level checks of the triangle unit normal block
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_defines.svh"

module tun_port_checks (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input tun_pkg::tun_out_t m_data
);
    import tun_pkg::*;

    logic norm_zero;
    logic stalled;

    assign norm_zero = (m_data.norm_x == '0) && (m_data.norm_y == '0)
                    && (m_data.norm_z == '0);
    assign stalled   = m_valid && !m_ready;

    `TUN_ASSERT_NEXT(a_hold_valid, aclk, aresetn, stalled, m_valid)
    `TUN_ASSERT_NEXT(a_hold_data, aclk, aresetn, stalled, $stable(m_data))
    `TUN_ASSERT_SAME(a_degen_zero, aclk, aresetn, m_valid && m_data.degenerate, norm_zero)
    `TUN_ASSERT_SAME(a_unit_nonzero, aclk, aresetn, m_valid && !m_data.degenerate, !norm_zero)
    // an empty result register never holds off a request
    `TUN_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, s_valid && !m_valid, s_ready)

endmodule

bind triangle_unit_normal tun_port_checks u_tun_port_checks (.*);
